// ----- rtl/rfe_pkg.sv -----
package rfe_pkg;

    typedef enum logic [2:0] {
        KIND_SET    = 3'd0,
        KIND_LINEAR = 3'd1,
        KIND_ZERO   = 3'd2,
        KIND_CUBIC  = 3'd3,
        KIND_TICK   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_CUBIC  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture accepted item and decode it
        logic weight;    // advance weight pipeline by one step
        logic div_start; // load the three dividers
        logic div_step;  // one quotient bit per channel
        logic commit;    // write quotients to levels
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_calc; // accepted item needs a blend computation
        logic wt_done;
        logic div_done;
    } t_stat;

endpackage

// ----- rtl/rgb_fade_engine.sv -----
// Channel  | Dir | Handshake               | Payload
// s_axis   | in  | tvalid/tready           | tdata: kind, red, green, blue, steps; 40b
// m_axis   | out | tvalid/tready           | tdata: red, green, blue, fading, refreshed
//
// One item at a time. Set, linear or zero fade-start and idle-tick items go
// through accept, decode and result. Ticks of an active fade and cubic starts
// go through accept, the weight steps (three multiply steps and a handoff),
// then a restoring divide producing 3*STEP_BITS+8 quotient bits per channel,
// one bit a cycle, then the result.
// Reset (synchronous, active low) clears the levels and leaves the fader idle.
// The result waits in its register while m_axis_tready is low; input is held off.
module rgb_fade_engine
    import rfe_pkg::*;
#(
    parameter int STEP_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] kind, [10:3] target_red, [18:11] target_green,
    // [26:19] target_blue, [36:27] steps, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level,
    // [24] fading, [25] refreshed, [31:26] zero
    output logic [31:0] m_axis_tdata
);

    t_cmd       cmd;
    t_stat      stat;
    logic       busy;
    logic [7:0] red, green, blue;
    logic       fading, refr;

    assign s_axis_tready = !busy;

    rfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_fire (m_axis_tvalid && m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_out_valid(m_axis_tvalid)
    );

    rfe_dp #(.STEP_BITS(STEP_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (s_axis_tdata[2:0]),
        .i_red      (s_axis_tdata[10:3]),
        .i_green    (s_axis_tdata[18:11]),
        .i_blue     (s_axis_tdata[26:19]),
        .i_steps    (s_axis_tdata[36:27]),
        .o_stat     (stat),
        .o_red      (red),
        .o_green    (green),
        .o_blue     (blue),
        .o_fading   (fading),
        .o_refreshed(refr)
    );

    assign m_axis_tdata = {6'd0, refr, fading, blue, green, red};

endmodule

// ----- rtl/rfe_ctrl.sv -----
module rfe_ctrl
    import rfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_fire,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_state = ST_WEIGHT;
                end
            end
            ST_WEIGHT: begin
                if (!i_stat.need_calc) begin
                    n_state = ST_OUTPUT;
                end else if (i_stat.wt_done) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (i_out_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_in_fire;
            end
            ST_WEIGHT: begin
                o_cmd.weight = i_stat.need_calc;
                o_cmd.div_start = i_stat.need_calc && i_stat.wt_done;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.commit = i_stat.div_done;
            end
            ST_OUTPUT: begin
                o_out_valid = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE)
        else $error("load outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_fire |=> o_out_valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == ST_OUTPUT)
        else $error("commit without result");

endmodule

// ----- rtl/rfe_dp.sv -----
module rfe_dp
    import rfe_pkg::*;
#(
    parameter int STEP_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [9:0] i_steps,
    output t_stat      o_stat,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_fading,
    output logic       o_refreshed
);

    localparam int NB  = STEP_BITS;
    localparam int DW  = 3 * NB;       // width of N^3 and of weight p
    localparam int NW  = DW + 8;       // numerator width
    localparam int CW  = $clog2(NW + 1);
    localparam logic [NB-1:0] NMAX = {NB{1'b1}};

    logic [7:0]    r_lvl   [3];
    logic [7:0]    r_start [3];
    logic [7:0]    r_goal  [3];
    logic [NB-1:0] r_idx, r_tot;
    t_mode         r_mode;
    logic          r_refr, r_calc;

    // weight pipeline
    logic [2:0]    r_wcnt;
    logic [DW-1:0] r_den, r_w, r_a, r_b;

    // dividers
    logic [NW-1:0] r_num [3];
    logic [NW-1:0] r_rem [3];
    logic [7:0]    r_q   [3];
    logic [CW-1:0] r_dcnt;

    logic [7:0]    in_col [3];
    logic [NB-1:0] steps_c;
    logic [NB-1:0] idx_nx;

    assign in_col[0] = i_red;
    assign in_col[1] = i_green;
    assign in_col[2] = i_blue;

    always_comb begin
        if (NB < 10 && (32'(i_steps) > 32'(NMAX))) begin
            steps_c = NMAX;
        end else begin
            steps_c = NB'(i_steps);
        end
        if (steps_c == '0) begin
            steps_c = {{(NB - 1){1'b0}}, 1'b1};
        end
        idx_nx = (r_idx < r_tot) ? r_idx + 1'b1 : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_idx  <= '0;
            r_tot  <= {{(NB - 1){1'b0}}, 1'b1};
            r_refr <= 1'b0;
            r_calc <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_lvl[c]   <= '0;
                r_start[c] <= '0;
                r_goal[c]  <= '0;
            end
        end else if (i_cmd.load) begin
            r_calc <= 1'b0;
            r_refr <= 1'b0;
            case (i_kind)
                KIND_SET: begin
                    for (int c = 0; c < 3; c++) r_lvl[c] <= in_col[c];
                    r_mode <= MODE_IDLE;
                    r_idx  <= '0;
                    r_refr <= 1'b1;
                end
                KIND_LINEAR, KIND_ZERO, KIND_CUBIC: begin
                    for (int c = 0; c < 3; c++) begin
                        r_start[c] <= r_lvl[c];
                        r_goal[c]  <= (i_kind == KIND_ZERO) ? 8'd0 : in_col[c];
                    end
                    r_tot  <= steps_c;
                    r_idx  <= '0;
                    r_mode <= (i_kind == KIND_CUBIC) ? MODE_CUBIC : MODE_LINEAR;
                    if (i_kind == KIND_CUBIC) begin
                        r_calc <= 1'b1;
                        r_refr <= 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (r_mode != MODE_IDLE) begin
                        r_idx  <= idx_nx;
                        r_calc <= 1'b1;
                        r_refr <= 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.commit) begin
            for (int c = 0; c < 3; c++) r_lvl[c] <= r_q[c];
            if (r_idx >= r_tot) begin
                r_mode <= MODE_IDLE;
            end
        end
    end

    // Weight: step 0 a=i*i, b=n*n; 1 a=i^3, b=n^3 (den), w partial; 2 final (linear: w=i, den=n)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
        end else if (i_cmd.load) begin
            r_wcnt <= '0;
        end else if (i_cmd.weight) begin
            r_wcnt <= r_wcnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.weight) begin
            case (r_wcnt)
                3'd0: begin
                    r_a <= DW'(r_idx) * DW'(r_idx);
                    r_b <= DW'(r_tot) * DW'(r_tot);
                end
                3'd1: begin
                    r_w   <= DW'(3) * DW'(r_a[2*NB-1:0]) * DW'(r_tot);
                    r_a   <= r_a * DW'(r_idx);
                    r_den <= r_b * DW'(r_tot);
                end
                3'd2: begin
                    if (r_mode == MODE_CUBIC) begin
                        r_w <= r_w - (r_a << 1);
                    end else begin
                        r_w   <= DW'(r_idx);
                        r_den <= DW'(r_tot);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.need_calc = r_calc;
    assign o_stat.wt_done   = (r_wcnt == 3'd3);
    assign o_stat.div_done  = (r_dcnt == CW'(NW));

    // restoring divide, one quotient bit per cycle per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step && r_dcnt != CW'(NW)) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW:0] trial;
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.div_start) begin
                r_num[c] <= NW'(r_start[c]) * NW'(r_den - r_w)
                          + NW'(r_goal[c]) * NW'(r_w);
                r_rem[c] <= '0;
                r_q[c]   <= '0;
            end else if (i_cmd.div_step && r_dcnt != CW'(NW)) begin
                trial = {r_rem[c], r_num[c][NW-1]};
                r_num[c] <= r_num[c] << 1;
                if (trial >= {1'b0, NW'(r_den)}) begin
                    r_rem[c] <= NW'(trial - {1'b0, NW'(r_den)});
                    r_q[c]   <= {r_q[c][6:0], 1'b1};
                end else begin
                    r_rem[c] <= trial[NW-1:0];
                    r_q[c]   <= {r_q[c][6:0], 1'b0};
                end
            end
        end
    end

    assign o_red       = r_lvl[0];
    assign o_green     = r_lvl[1];
    assign o_blue      = r_lvl[2];
    assign o_fading    = (r_mode != MODE_IDLE);
    assign o_refreshed = r_refr;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot != '0)
        else $error("zero step total");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_IDLE |-> r_idx <= r_tot)
        else $error("step index past total");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dcnt == '0)
        else $error("divider not restarted");

endmodule
